// File: sv/pse_pkg.sv
package pse_pkg;

    localparam int MAX_LIMIT  = 65536;
    localparam int MAX_PRIMES = 8192;

    // field widths of the request and result items
    localparam int LIMIT_W = 17;
    localparam int IDX_W   = 13;
    localparam int PRIME_W = 17;
    localparam int CNT_W   = 14;

    // one map bit per odd number up to MAX_LIMIT
    localparam int MAP_DEPTH = MAX_LIMIT / 2;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int LIST_AW   = $clog2(MAX_PRIMES);

    // working values reach the bound plus one stride
    localparam int VAL_W = $clog2(MAX_LIMIT + 1) + 1;
    localparam int P_W   = VAL_W / 2 + 1;

    localparam logic REQ_SIEVE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_READ,
        TS_SIEVE
    } t_top_state;

    typedef enum logic [2:0] {
        SV_IDLE,
        SV_CLEAR,
        SV_TWO,
        SV_PTEST,
        SV_PCHK,
        SV_MARK,
        SV_SCAN
    } t_sv_state;

    typedef struct packed {
        logic               we;
        logic [LIST_AW-1:0] addr;
        logic [PRIME_W-1:0] data;
    } t_list_wr;

endpackage

// File: sv/pse_ram.sv
module pse_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/pse_sieve.sv
module pse_sieve
    import pse_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_busy,
    output logic [CNT_W-1:0]   o_count,
    output t_list_wr           o_list_wr
);

    t_sv_state r_state, n_state;
    logic [VAL_W-1:0]  r_bound, n_bound;
    logic [MAP_AW-1:0] r_addr, n_addr;
    logic [P_W-1:0]    r_p, n_p;
    logic [VAL_W-1:0]  r_psq, n_psq;
    logic [VAL_W-1:0]  r_j, n_j;
    logic [VAL_W-1:0]  r_step, n_step;
    logic [VAL_W-1:0]  r_x, n_x;
    logic [VAL_W-1:0]  r_px, n_px;
    logic              r_pend, n_pend;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              w_map_we;
    logic [MAP_AW-1:0] w_map_waddr;
    logic              w_map_wdata;
    logic [MAP_AW-1:0] w_map_raddr;
    logic              w_map_rdata;

    logic [VAL_W-1:0]  w_sat;
    logic [VAL_W-1:0]  w_bm1;
    logic [MAP_AW-1:0] w_last;
    logic [VAL_W-1:0]  w_psq_next;
    logic              w_list_room;

    pse_ram #(
        .DEPTH (MAP_DEPTH),
        .WIDTH (1)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata)
    );

    assign w_sat = (VAL_W'(i_limit) > VAL_W'(MAX_LIMIT)) ? VAL_W'(MAX_LIMIT) : VAL_W'(i_limit);
    // highest map entry in use: (bound - 1) / 2
    assign w_bm1 = r_bound - VAL_W'(1);
    assign w_last = w_bm1[MAP_AW:1];
    // (p + 2)^2 = p^2 + 4p + 4
    assign w_psq_next = r_psq + VAL_W'({r_p, 2'b00}) + VAL_W'(4);
    assign w_list_room = r_count < CNT_W'(MAX_PRIMES);

    always_comb begin
        n_state = r_state;
        n_bound = r_bound;
        n_addr  = r_addr;
        n_p     = r_p;
        n_psq   = r_psq;
        n_j     = r_j;
        n_step  = r_step;
        n_x     = r_x;
        n_px    = r_px;
        n_pend  = 1'b0;
        n_count = r_count;
        unique case (r_state)
            SV_IDLE: begin
                if (i_start) begin
                    n_bound = w_sat;
                    n_addr  = '0;
                    n_count = '0;
                    if (w_sat >= VAL_W'(2)) begin
                        n_state = SV_CLEAR;
                    end
                end
            end
            SV_CLEAR: begin
                n_addr = r_addr + MAP_AW'(1);
                if (r_addr == w_last) begin
                    n_state = SV_TWO;
                end
            end
            SV_TWO: begin
                n_count = CNT_W'(1);
                n_p     = P_W'(3);
                n_psq   = VAL_W'(9);
                n_state = SV_PTEST;
            end
            SV_PTEST: begin
                if (r_psq <= r_bound) begin
                    n_state = SV_PCHK;
                end else begin
                    n_x     = VAL_W'(3);
                    n_state = SV_SCAN;
                end
            end
            SV_PCHK: begin
                if (w_map_rdata) begin
                    n_p     = r_p + P_W'(2);
                    n_psq   = w_psq_next;
                    n_state = SV_PTEST;
                end else begin
                    n_j     = r_psq;
                    n_step  = VAL_W'({r_p, 1'b0});
                    n_state = SV_MARK;
                end
            end
            SV_MARK: begin
                if (r_j <= r_bound) begin
                    n_j = r_j + r_step;
                end else begin
                    n_p     = r_p + P_W'(2);
                    n_psq   = w_psq_next;
                    n_state = SV_PTEST;
                end
            end
            SV_SCAN: begin
                // read of x issued now, its map bit checked next cycle
                n_px = r_x;
                if (r_x <= r_bound) begin
                    n_pend = 1'b1;
                    n_x    = r_x + VAL_W'(2);
                end
                if (r_pend && !w_map_rdata && w_list_room) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (!(r_x <= r_bound) && !r_pend) begin
                    n_state = SV_IDLE;
                end
            end
            default: n_state = SV_IDLE;
        endcase
    end

    always_comb begin
        w_map_we       = 1'b0;
        w_map_waddr    = r_addr;
        w_map_wdata    = 1'b0;
        w_map_raddr    = r_x[MAP_AW:1];
        o_list_wr.we   = 1'b0;
        o_list_wr.addr = r_count[LIST_AW-1:0];
        o_list_wr.data = PRIME_W'(r_px);
        unique case (r_state)
            SV_CLEAR: begin
                w_map_we = 1'b1;
            end
            SV_TWO: begin
                o_list_wr.we   = 1'b1;
                o_list_wr.addr = '0;
                o_list_wr.data = PRIME_W'(2);
            end
            SV_PTEST: begin
                w_map_raddr = MAP_AW'(r_p >> 1);
            end
            SV_MARK: begin
                w_map_we    = r_j <= r_bound;
                w_map_waddr = r_j[MAP_AW:1];
                w_map_wdata = 1'b1;
            end
            SV_SCAN: begin
                o_list_wr.we = r_pend && !w_map_rdata && w_list_room;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SV_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_bound <= n_bound;
        r_addr  <= n_addr;
        r_p     <= n_p;
        r_psq   <= n_psq;
        r_j     <= n_j;
        r_step  <= n_step;
        r_x     <= n_x;
        r_px    <= n_px;
    end

    assign o_busy  = r_state != SV_IDLE;
    assign o_count = r_count;

endmodule

// File: sv/prime_sieve_engine_top.sv
// channel   direction  handshake                 payload
// request   in         i_in_valid / o_in_ready   i_req_type, i_limit, i_index
// result    out        o_out_valid / i_out_ready o_prime, o_prime_count, o_valid_res
//
// read: served from the registered prime-list read; no new request meanwhile
// sieve of bound n: clear the bitmap, mark multiples of odd primes up to sqrt(n),
//   then scan the odd numbers into the prime list; one bitmap RAM, one read port
// reset clears control only; every sieve run clears the bitmap it uses
// a finished result waits in the output register; a new request is taken meanwhile
module prime_sieve_engine_top
    import pse_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [LIMIT_W-1:0] i_limit,
    input  logic [IDX_W-1:0]   i_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PRIME_W-1:0] o_prime,
    output logic [CNT_W-1:0]   o_prime_count,
    output logic               o_valid_res
);

    t_top_state r_state, n_state;
    logic [IDX_W-1:0]   r_index;
    logic               r_out_vld, n_out_vld;
    logic [PRIME_W-1:0] r_prime;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_vres;

    logic               w_accept;
    logic               w_start;
    logic               w_done;
    logic               w_load;
    logic               w_hit;
    logic               w_busy;
    logic [CNT_W-1:0]   w_count;
    t_list_wr           w_list_wr;
    logic [LIST_AW-1:0] w_list_raddr;
    logic [PRIME_W-1:0] w_list_rdata;

    pse_sieve u_sieve (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_limit   (i_limit),
        .o_busy    (w_busy),
        .o_count   (w_count),
        .o_list_wr (w_list_wr)
    );

    pse_ram #(
        .DEPTH (MAX_PRIMES),
        .WIDTH (PRIME_W)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (w_list_wr.we),
        .i_waddr (w_list_wr.addr),
        .i_wdata (w_list_wr.data),
        .i_raddr (w_list_raddr),
        .o_rdata (w_list_rdata)
    );

    assign w_accept = i_in_valid && o_in_ready;
    // read address follows the request in the transfer cycle, then holds
    assign w_list_raddr = (r_state == TS_IDLE) ? LIST_AW'(i_index) : LIST_AW'(r_index);
    assign w_hit = CNT_W'(r_index) < w_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req_type == REQ_READ) ? TS_READ : TS_SIEVE;
                end
            end
            TS_READ, TS_SIEVE: begin
                if (w_load) begin
                    n_state = TS_IDLE;
                end
            end
            default: n_state = TS_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_start    = 1'b0;
        w_done     = 1'b0;
        unique case (r_state)
            TS_IDLE: begin
                o_in_ready = 1'b1;
                w_start    = i_in_valid && (i_req_type == REQ_SIEVE);
            end
            TS_READ: begin
                w_done = 1'b1;
            end
            TS_SIEVE: begin
                w_done = !w_busy;
            end
            default: begin
            end
        endcase
        w_load = w_done && (!r_out_vld || i_out_ready);
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= TS_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        if (w_accept) begin
            r_index <= i_index;
        end
        if (w_load) begin
            r_cnt <= w_count;
            if (r_state == TS_READ && w_hit) begin
                r_prime <= w_list_rdata;
                r_vres  <= 1'b1;
            end else begin
                r_prime <= '0;
                r_vres  <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_prime       = r_prime;
    assign o_prime_count = r_cnt;
    assign o_valid_res   = r_vres;

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_in_ready)
        else $error("request taken while sieve runs");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(MAX_PRIMES))
        else $error("prime count past list depth");

    a_hit_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |-> (o_prime_count != '0 && o_prime != '0))
        else $error("valid read with empty list");

    a_sieve_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TS_SIEVE && w_load) |=> (o_out_valid && !o_valid_res && o_prime == '0))
        else $error("sieve result carries a prime");

endmodule

// File: tb/sieve_answer_pkg.sv
package sieve_answer_pkg;
    import pse_pkg::*;

    typedef struct {
        logic [PRIME_W-1:0] prime;
        logic [CNT_W-1:0]   prime_count;
        logic               valid;
    } t_answer;

    class prime_table;
        bit                 composite[MAP_DEPTH+1];
        logic [PRIME_W-1:0] primes[MAX_PRIMES];
        int unsigned        found;
        int unsigned        mismatches;
        t_answer            pending_answers[$];

        function new();
            found      = 0;
            mismatches = 0;
        endfunction

        function void sieve(int unsigned bound);
            int unsigned p;
            int unsigned j;
            int unsigned x;
            if (bound > MAX_LIMIT) begin
                bound = MAX_LIMIT;
            end
            foreach (composite[k]) begin
                composite[k] = 1'b0;
            end
            found = 0;
            if (bound < 2) begin
                return;
            end
            primes[0] = 2;
            found     = 1;
            // one bit per odd number, index is value / 2
            for (p = 3; p * p <= bound; p += 2) begin
                if (!composite[p >> 1]) begin
                    for (j = p * p; j <= bound; j += 2 * p) begin
                        composite[j >> 1] = 1'b1;
                    end
                end
            end
            for (x = 3; x <= bound && found < MAX_PRIMES; x += 2) begin
                if (!composite[x >> 1]) begin
                    primes[found] = PRIME_W'(x);
                    found++;
                end
            end
        endfunction

        function void take_request(logic req_type, logic [LIMIT_W-1:0] limit,
                                   logic [IDX_W-1:0] index);
            t_answer a;
            a.prime = '0;
            a.valid = 1'b0;
            if (req_type == REQ_SIEVE) begin
                sieve(limit);
            end else if (index < found) begin
                a.prime = primes[index];
                a.valid = 1'b1;
            end
            a.prime_count = CNT_W'(found);
            pending_answers.push_back(a);
        endfunction

        function void match_answer(logic [PRIME_W-1:0] prime, logic [CNT_W-1:0] prime_count,
                                   logic valid);
            t_answer e;
            if (pending_answers.size() == 0) begin
                $error("result with no request outstanding: prime %0d count %0d valid %0d",
                       prime, prime_count, valid);
                mismatches++;
                return;
            end
            e = pending_answers.pop_front();
            if (prime !== e.prime) begin
                $error("prime: expected %0d, got %0d", e.prime, prime);
                mismatches++;
            end
            if (prime_count !== e.prime_count) begin
                $error("prime_count: expected %0d, got %0d", e.prime_count, prime_count);
                mismatches++;
            end
            if (valid !== e.valid) begin
                $error("valid_res: expected %0d, got %0d", e.valid, valid);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

endpackage

// File: tb/tb_top.sv
module tb_top;
    import pse_pkg::*;
    import sieve_answer_pkg::*;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic               i_req_type  = 1'b0;
    logic [LIMIT_W-1:0] i_limit     = '0;
    logic [IDX_W-1:0]   i_index     = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [PRIME_W-1:0] o_prime;
    logic [CNT_W-1:0]   o_prime_count;
    logic               o_valid_res;

    prime_table  tracker;
    int unsigned send_max_gap = 4;
    int unsigned recv_max_gap = 4;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;

    prime_sieve_engine_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_limit       (i_limit),
        .i_index       (i_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_prime       (o_prime),
        .o_prime_count (o_prime_count),
        .o_valid_res   (o_valid_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("tb_top failed");
        $finish;
    end

    task automatic push_request(input logic req_type, input logic [LIMIT_W-1:0] limit,
                                input logic [IDX_W-1:0] index);
        int unsigned gap;
        if (items_sent % 64 == 0) begin
            send_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
        end
        gap = $urandom_range(0, send_max_gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req_type;
        i_limit    <= limit;
        i_index    <= index;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_request(req_type, limit, index);
        items_sent++;
    endtask

    task automatic collect_results();
        int unsigned gap;
        forever begin
            // long hold-off lets the block fill and push back on requests
            if (results_seen == 150 || results_seen == 500) begin
                gap = 400;
            end else begin
                gap = $urandom_range(0, recv_max_gap);
            end
            @(negedge i_clk);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            tracker.match_answer(o_prime, o_prime_count, o_valid_res);
            results_seen++;
            if (results_seen % 64 == 0) begin
                recv_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
            end
        end
    endtask

    initial begin
        logic               rt;
        logic [LIMIT_W-1:0] lim;
        logic [IDX_W-1:0]   idx;
        int unsigned        r;
        int unsigned        large_left;
        int unsigned        drain;

        tracker    = new();
        large_left = 2;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            collect_results();
        join_none

        // reads before any sieve, then tiny bounds around the first primes
        push_request(REQ_READ,  '0, '0);
        push_request(REQ_READ,  LIMIT_W'(MAX_LIMIT), '1);
        push_request(REQ_SIEVE, '0, '1);
        push_request(REQ_READ,  '0, '0);
        push_request(REQ_SIEVE, LIMIT_W'(1), '0);
        push_request(REQ_READ,  '0, '0);
        push_request(REQ_SIEVE, LIMIT_W'(2), '0);
        push_request(REQ_READ,  '0, '0);
        push_request(REQ_READ,  '0, IDX_W'(1));
        push_request(REQ_SIEVE, LIMIT_W'(3), '0);
        push_request(REQ_READ,  '0, IDX_W'(1));
        push_request(REQ_SIEVE, LIMIT_W'(9), '0);
        push_request(REQ_READ,  '0, IDX_W'(3));
        push_request(REQ_READ,  '0, IDX_W'(4));
        push_request(REQ_SIEVE, LIMIT_W'(25), '0);
        push_request(REQ_READ,  '0, IDX_W'(8));
        push_request(REQ_READ,  '0, IDX_W'(9));
        // full-size run: last stored prime, one past it, top index
        push_request(REQ_SIEVE, LIMIT_W'(MAX_LIMIT), '1);
        push_request(REQ_READ,  '0, IDX_W'(tracker.found - 1));
        push_request(REQ_READ,  '1, IDX_W'(tracker.found));
        push_request(REQ_READ,  '0, '1);
        push_request(REQ_READ,  '0, '0);
        push_request(REQ_SIEVE, LIMIT_W'(121), '0);
        push_request(REQ_READ,  '0, IDX_W'(tracker.found - 1));

        repeat (830) begin
            r   = $urandom_range(0, 99);
            lim = LIMIT_W'($urandom_range(0, MAX_LIMIT));
            idx = IDX_W'($urandom_range(0, MAX_PRIMES - 1));
            if (r < 8) begin
                rt = REQ_SIEVE;
                // big bounds make long sieve runs, keep them rare
                if (large_left > 0 && $urandom_range(0, 24) == 0) begin
                    lim = LIMIT_W'($urandom_range(30000, MAX_LIMIT));
                    large_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    lim = LIMIT_W'($urandom_range(0, 40));
                end else begin
                    lim = LIMIT_W'($urandom_range(41, 3000));
                end
            end else if (r < 83) begin
                rt = REQ_READ;
                if (tracker.found > 0) begin
                    idx = IDX_W'($urandom_range(0, tracker.found - 1));
                end
            end else begin
                rt = REQ_READ;
                if ($urandom_range(0, 1) == 0) begin
                    idx = IDX_W'(tracker.found + $urandom_range(0, 2));
                end
            end
            push_request(rt, lim, idx);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        drain = 0;
        while (tracker.pending() > 0 && drain < 500000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);

        if (tracker.pending() > 0) begin
            $error("%0d results never arrived", tracker.pending());
        end
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
